/* hdl/cems_pkg.sv */
// ----------------------------------------------------------------------------
// cems_pkg
// Shared codes, widths and control/status bundles of the clock estimate
// mode selector.
// ----------------------------------------------------------------------------
package cems_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CONF_W   = 7;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned DVD_W    = WORD_W + SCALE_W;
  localparam int unsigned CNT_W    = $clog2(DVD_W);

  localparam logic [SCALE_W-1:0] MS_PER_S         = SCALE_W'(1000);
  localparam logic [WORD_W-1:0]  LONG_HOLDOVER_MS = WORD_W'(600000);
  localparam logic [WORD_W-1:0]  NOMINAL_RESET    = WORD_W'(16000000);
  localparam logic [WORD_W-1:0]  GRACE_RESET      = WORD_W'(5000);

  localparam logic CMD_SYNC = 1'b0;
  localparam logic CMD_CONV = 1'b1;

  localparam logic REG_NOMINAL = 1'b0;
  localparam logic REG_GRACE   = 1'b1;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_ACQ  = 2'd1;
  localparam logic [1:0] ST_DISC = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  localparam logic [2:0] MD_NOMINAL  = 3'd0;
  localparam logic [2:0] MD_BLEND    = 3'd1;
  localparam logic [2:0] MD_SLOW     = 3'd2;
  localparam logic [2:0] MD_GRACE    = 3'd3;
  localparam logic [2:0] MD_HOLDOVER = 3'd4;

  localparam logic [CONF_W-1:0] CONF_DISC      = CONF_W'(100);
  localparam logic [CONF_W-1:0] CONF_ACQ       = CONF_W'(70);
  localparam logic [CONF_W-1:0] CONF_HOLD      = CONF_W'(50);
  localparam logic [CONF_W-1:0] CONF_HOLD_LONG = CONF_W'(20);
  localparam logic [CONF_W-1:0] CONF_FREE      = CONF_W'(10);

  typedef struct packed {
    logic load_sync;
    logic load_conv;
    logic div_step;
    logic emit;
  } cems_cmd_t;

  typedef struct packed {
    logic tps_zero;
    logic div_last;
  } cems_sts_t;

endpackage

/* hdl/cems_ctrl.sv */
// ----------------------------------------------------------------------------
// cems_ctrl
// Sequencer: takes one item, runs the divider for a conversion with a nonzero
// estimate, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cems_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  output logic               out_valid,
  input  logic               out_stall,
  input  cems_pkg::cems_sts_t sts,
  output cems_pkg::cems_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    ctl.load_sync = accept && (cmd == cems_pkg::CMD_SYNC);
    ctl.load_conv = accept && (cmd == cems_pkg::CMD_CONV);
    ctl.div_step  = 1'b0;
    ctl.emit      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((cmd == cems_pkg::CMD_CONV) && !sts.tps_zero) state_next = S_DIV;
          else state_next = S_FIN;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

/* hdl/cems_dp.sv */
// ----------------------------------------------------------------------------
// cems_dp
// Datapath: configuration, discipliner status, mode and estimate registers,
// bit-serial restoring divider for the millisecond conversion, result register.
// ----------------------------------------------------------------------------
module cems_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [cems_pkg::WORD_W-1:0]       cfg_data,
  input  logic [1:0]                        lock_state,
  input  logic                              pps_present,
  input  logic [cems_pkg::WORD_W-1:0]       now_ms,
  input  logic [cems_pkg::WORD_W-1:0]       applied_hz,
  input  logic [cems_pkg::WORD_W-1:0]       slow_hz,
  input  logic [cems_pkg::WORD_W-1:0]       last_good_hz,
  input  logic [cems_pkg::WORD_W-1:0]       holdover_ms,
  input  logic [cems_pkg::WORD_W-1:0]       tick_count,
  input  cems_pkg::cems_cmd_t               ctl,
  output cems_pkg::cems_sts_t               sts,
  output logic [cems_pkg::WORD_W-1:0]       ticks_per_second,
  output logic [2:0]                        est_mode,
  output logic [1:0]                        current_state,
  output logic                              pps_flag,
  output logic [cems_pkg::WORD_W-1:0]       holdover_age,
  output logic [cems_pkg::CONF_W-1:0]       confidence,
  output logic [cems_pkg::WORD_W-1:0]       millis
);

  localparam int unsigned W = cems_pkg::WORD_W;
  localparam int unsigned D = cems_pkg::DVD_W;

  logic [W-1:0] nominal_hz, grace_window_ms;
  logic [1:0]   lock_state_reg;
  logic [2:0]   mode_reg;
  logic [W-1:0] freq_estimate, anchor_hz, grace_start, holdover_reg;
  logic         pps_reg, ever_locked;

  logic [W-1:0] tps;
  logic         mild, locked_next, grace_over;
  logic [W-1:0] anchor_next, elapsed, freq_pick;
  logic [2:0]   mode_next;
  logic [cems_pkg::CONF_W-1:0] conf_now;

  logic [D-1:0] dvd;
  logic [W-1:0] rem, div_tps;
  logic [W:0]   trial, diff;
  logic         trial_ge;
  logic [cems_pkg::CNT_W-1:0] cnt;
  logic         conv_ok;

  assign tps          = (freq_estimate != '0) ? freq_estimate : nominal_hz;
  assign sts.tps_zero = (tps == '0);
  assign sts.div_last = (cnt == cems_pkg::CNT_W'(D - 1));

  // sync update
  assign mild        = (lock_state_reg == cems_pkg::ST_DISC) &&
                       (lock_state == cems_pkg::ST_ACQ) && pps_present;
  assign locked_next = ever_locked || (lock_state == cems_pkg::ST_DISC);
  assign anchor_next = mild ? ((last_good_hz != '0) ? last_good_hz : nominal_hz)
                            : anchor_hz;
  assign elapsed     = now_ms - grace_start;
  assign grace_over  = (elapsed >= grace_window_ms) || !pps_present || !locked_next;

  always_comb begin
    case (lock_state)
      cems_pkg::ST_FREE: mode_next = cems_pkg::MD_NOMINAL;
      cems_pkg::ST_DISC: mode_next = cems_pkg::MD_SLOW;
      cems_pkg::ST_HOLD: mode_next = cems_pkg::MD_HOLDOVER;
      default: begin
        if (mild) mode_next = cems_pkg::MD_GRACE;
        else if ((mode_reg == cems_pkg::MD_GRACE) && !grace_over)
          mode_next = cems_pkg::MD_GRACE;
        else mode_next = cems_pkg::MD_BLEND;
      end
    endcase
  end

  always_comb begin
    case (mode_next)
      cems_pkg::MD_BLEND:    freq_pick = applied_hz;
      cems_pkg::MD_SLOW:     freq_pick = slow_hz;
      cems_pkg::MD_GRACE:    freq_pick = anchor_next;
      cems_pkg::MD_HOLDOVER: freq_pick = last_good_hz;
      default:               freq_pick = nominal_hz;
    endcase
  end

  always_comb begin
    case (lock_state_reg)
      cems_pkg::ST_DISC: conf_now = cems_pkg::CONF_DISC;
      cems_pkg::ST_ACQ:  conf_now = cems_pkg::CONF_ACQ;
      cems_pkg::ST_HOLD: conf_now = (holdover_reg > cems_pkg::LONG_HOLDOVER_MS)
                                    ? cems_pkg::CONF_HOLD_LONG : cems_pkg::CONF_HOLD;
      default:           conf_now = cems_pkg::CONF_FREE;
    endcase
  end

  // restoring divider step
  assign trial    = {rem, dvd[D-1]};
  assign diff     = trial - {1'b0, div_tps};
  assign trial_ge = (trial >= {1'b0, div_tps});

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_hz      <= cems_pkg::NOMINAL_RESET;
      grace_window_ms <= cems_pkg::GRACE_RESET;
      lock_state_reg  <= cems_pkg::ST_FREE;
      mode_reg        <= cems_pkg::MD_NOMINAL;
      freq_estimate   <= cems_pkg::NOMINAL_RESET;
      anchor_hz       <= cems_pkg::NOMINAL_RESET;
      grace_start     <= '0;
      pps_reg         <= 1'b0;
      ever_locked     <= 1'b0;
      holdover_reg    <= '0;
      conv_ok         <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cems_pkg::REG_NOMINAL) nominal_hz <= cfg_data;
        else grace_window_ms <= cfg_data;
      end
      if (ctl.load_sync) begin
        lock_state_reg <= lock_state;
        pps_reg        <= pps_present;
        holdover_reg   <= holdover_ms;
        ever_locked    <= locked_next;
        anchor_hz      <= anchor_next;
        if (mild) grace_start <= now_ms;
        mode_reg       <= mode_next;
        freq_estimate  <= (freq_pick != '0) ? freq_pick : nominal_hz;
        conv_ok        <= 1'b0;
      end
      if (ctl.load_conv) conv_ok <= !sts.tps_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_conv) begin
      dvd     <= D'(tick_count) * D'(cems_pkg::MS_PER_S) + D'(tps >> 1);
      rem     <= '0;
      div_tps <= tps;
      cnt     <= '0;
    end else if (ctl.div_step) begin
      dvd <= {dvd[D-2:0], trial_ge};
      rem <= trial_ge ? diff[W-1:0] : trial[W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      ticks_per_second <= tps;
      est_mode         <= mode_reg;
      current_state    <= lock_state_reg;
      pps_flag         <= pps_reg;
      holdover_age     <= holdover_reg;
      confidence       <= conf_now;
      millis           <= conv_ok ? dvd[W-1:0] : '0;
    end
  end

endmodule

/* hdl/clock_estimate_mode_selector_core.sv */
// ----------------------------------------------------------------------------
// clock_estimate_mode_selector_core
// Chooses the exported clock-frequency estimate and converts ticks to ms.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one item: cmd selects a sync
// update from the discipliner or a tick-to-millisecond conversion. Output
// channel (out_valid/out_stall) returns exactly one result per item.
// Registers nominal_hz (index 0) and grace_window_ms (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// item is in flight, which the block itself does not enforce. An accepted
// sync goes to S_FIN, whose result is loaded into the output register once
// that register is free; a conversion first runs the 42-step restoring
// divider in S_DIV, retiring one quotient bit per cycle. A conversion with a
// zero estimate skips the divider. One item is in work at a time; in_stall is
// high from acceptance until the result is loaded into the output register.
// The output register holds a result while out_stall is high; the next item
// can be accepted and worked on meanwhile, and its result waits until the
// held one is transferred.
// Reset (rst, synchronous) restores register defaults, free-run state and
// nominal mode, and empties the output register.
// ----------------------------------------------------------------------------
module clock_estimate_mode_selector_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [cems_pkg::WORD_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [1:0]                   lock_state,
  input  logic                         pps_present,
  input  logic [cems_pkg::WORD_W-1:0]  now_ms,
  input  logic [cems_pkg::WORD_W-1:0]  applied_hz,
  input  logic [cems_pkg::WORD_W-1:0]  slow_hz,
  input  logic [cems_pkg::WORD_W-1:0]  last_good_hz,
  input  logic [cems_pkg::WORD_W-1:0]  holdover_ms,
  input  logic [cems_pkg::WORD_W-1:0]  tick_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cems_pkg::WORD_W-1:0]  ticks_per_second,
  output logic [2:0]                   est_mode,
  output logic [1:0]                   current_state,
  output logic                         pps_flag,
  output logic [cems_pkg::WORD_W-1:0]  holdover_age,
  output logic [cems_pkg::CONF_W-1:0]  confidence,
  output logic [cems_pkg::WORD_W-1:0]  millis
);

  cems_pkg::cems_cmd_t ctl;
  cems_pkg::cems_sts_t sts;

  cems_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  cems_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .lock_state       (lock_state),
    .pps_present      (pps_present),
    .now_ms           (now_ms),
    .applied_hz       (applied_hz),
    .slow_hz          (slow_hz),
    .last_good_hz     (last_good_hz),
    .holdover_ms      (holdover_ms),
    .tick_count       (tick_count),
    .ctl              (ctl),
    .sts              (sts),
    .ticks_per_second (ticks_per_second),
    .est_mode         (est_mode),
    .current_state    (current_state),
    .pps_flag         (pps_flag),
    .holdover_age     (holdover_age),
    .confidence       (confidence),
    .millis           (millis)
  );

endmodule

/* hdl/cems_chk.sv */
// ----------------------------------------------------------------------------
// cems_chk
// Port-level checks for the clock estimate mode selector, bound to the top.
// ----------------------------------------------------------------------------
module cems_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [cems_pkg::WORD_W-1:0]  ticks_per_second,
  input logic [2:0]                   est_mode,
  input logic [1:0]                   current_state,
  input logic [cems_pkg::CONF_W-1:0]  confidence,
  input logic [cems_pkg::WORD_W-1:0]  millis
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output register not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(millis) &&
                               $stable(ticks_per_second))
    else $error("stalled result changed");

  a_mode_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((est_mode == cems_pkg::MD_NOMINAL)  && (current_state == cems_pkg::ST_FREE)) ||
      ((est_mode == cems_pkg::MD_SLOW)     && (current_state == cems_pkg::ST_DISC)) ||
      ((est_mode == cems_pkg::MD_HOLDOVER) && (current_state == cems_pkg::ST_HOLD)) ||
      ((est_mode == cems_pkg::MD_BLEND)    && (current_state == cems_pkg::ST_ACQ))  ||
      ((est_mode == cems_pkg::MD_GRACE)    && (current_state == cems_pkg::ST_ACQ)))
    else $error("export mode does not fit discipliner state");

  a_zero_tps: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ticks_per_second == '0) |-> (millis == '0))
    else $error("millis nonzero with zero estimate");

  a_conf_disc: assert property (@(posedge clk) disable iff (rst)
    out_valid && (current_state == cems_pkg::ST_DISC) |->
      (confidence == cems_pkg::CONF_DISC))
    else $error("confidence wrong while disciplined");

endmodule

bind clock_estimate_mode_selector_core cems_chk u_cems_chk (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock estimate mode selector. Sync and convert
// items go in through the valid/stall input channel. A predictor runs
// alongside and updates the state, mode, latched estimate and grace window at
// each accepted sync item. Each output transfer is checked field by field
// against the oldest expected status. Directed cases cover the mode walk,
// register extremes and back-pressure. Random phases then drive lock/unlock
// sequences with random content under several register settings and random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        cmd;
    logic [1:0]                  state;
    logic                        pps;
    logic [cems_pkg::WORD_W-1:0] now;
    logic [cems_pkg::WORD_W-1:0] applied;
    logic [cems_pkg::WORD_W-1:0] slow;
    logic [cems_pkg::WORD_W-1:0] good;
    logic [cems_pkg::WORD_W-1:0] age;
    logic [cems_pkg::WORD_W-1:0] ticks;
  } item_t;

  typedef struct packed {
    logic [cems_pkg::WORD_W-1:0] tps;
    logic [2:0]                  mode;
    logic [1:0]                  state;
    logic                        pps;
    logic [cems_pkg::WORD_W-1:0] age;
    logic [cems_pkg::CONF_W-1:0] conf;
    logic [cems_pkg::WORD_W-1:0] millis;
  } export_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        cfg_we;
  logic                        cfg_index;
  logic [cems_pkg::WORD_W-1:0] cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic                        cmd;
  logic [1:0]                  lock_state;
  logic                        pps_present;
  logic [cems_pkg::WORD_W-1:0] now_ms;
  logic [cems_pkg::WORD_W-1:0] applied_hz;
  logic [cems_pkg::WORD_W-1:0] slow_hz;
  logic [cems_pkg::WORD_W-1:0] last_good_hz;
  logic [cems_pkg::WORD_W-1:0] holdover_ms;
  logic [cems_pkg::WORD_W-1:0] tick_count;
  logic                        out_valid;
  logic                        out_stall;
  logic [cems_pkg::WORD_W-1:0] ticks_per_second;
  logic [2:0]                  est_mode;
  logic [1:0]                  current_state;
  logic                        pps_flag;
  logic [cems_pkg::WORD_W-1:0] holdover_age;
  logic [cems_pkg::CONF_W-1:0] confidence;
  logic [cems_pkg::WORD_W-1:0] millis;

  // predictor state and register copies
  logic [cems_pkg::WORD_W-1:0] nom_hz;
  logic [cems_pkg::WORD_W-1:0] grace_len;
  logic [1:0]                  sel_state;
  logic [2:0]                  sel_mode;
  logic [cems_pkg::WORD_W-1:0] sel_freq;
  logic [cems_pkg::WORD_W-1:0] sel_anchor;
  logic [cems_pkg::WORD_W-1:0] sel_grace_t0;
  logic                        sel_pps;
  logic                        sel_locked;
  logic [cems_pkg::WORD_W-1:0] sel_age;

  export_t     export_due[$];
  export_t     exp_r;
  export_t     got_r;
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_off = 0;
  logic [cems_pkg::WORD_W-1:0] wall_ms = '0;

  clock_estimate_mode_selector_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic export_t compute_export(input item_t it);
    logic [1:0]                  prior;
    logic                        mild;
    logic [cems_pkg::WORD_W-1:0] pick;
    logic [cems_pkg::WORD_W-1:0] tps;
    logic [cems_pkg::WORD_W-1:0] elapsed;
    logic [63:0]                 scaled;
    export_t                     r;
    r.millis = '0;
    if (it.cmd == cems_pkg::CMD_SYNC) begin
      prior = sel_state;
      sel_state = it.state;
      sel_pps = it.pps;
      sel_age = it.age;
      mild = (prior == cems_pkg::ST_DISC) && (it.state == cems_pkg::ST_ACQ) && it.pps;
      if (it.state == cems_pkg::ST_DISC) sel_locked = 1'b1;
      if (mild) begin
        sel_grace_t0 = it.now;
        sel_anchor = (it.good != '0) ? it.good : nom_hz;
      end
      elapsed = it.now - sel_grace_t0;
      case (it.state)
        cems_pkg::ST_FREE: sel_mode = cems_pkg::MD_NOMINAL;
        cems_pkg::ST_DISC: sel_mode = cems_pkg::MD_SLOW;
        cems_pkg::ST_HOLD: sel_mode = cems_pkg::MD_HOLDOVER;
        default: begin
          if (mild) sel_mode = cems_pkg::MD_GRACE;
          else if (sel_mode != cems_pkg::MD_GRACE || elapsed >= grace_len || !it.pps ||
                   !sel_locked)
            sel_mode = cems_pkg::MD_BLEND;
        end
      endcase
      case (sel_mode)
        cems_pkg::MD_BLEND:    pick = it.applied;
        cems_pkg::MD_SLOW:     pick = it.slow;
        cems_pkg::MD_GRACE:    pick = sel_anchor;
        cems_pkg::MD_HOLDOVER: pick = it.good;
        default:               pick = nom_hz;
      endcase
      sel_freq = (pick != '0) ? pick : nom_hz;
    end
    tps = (sel_freq != '0) ? sel_freq : nom_hz;
    if (it.cmd == cems_pkg::CMD_CONV && tps != '0) begin
      scaled = {32'd0, it.ticks} * 64'd1000 + {32'd0, tps >> 1};
      r.millis = 32'(scaled / {32'd0, tps});
    end
    r.tps = tps;
    r.mode = sel_mode;
    r.state = sel_state;
    r.pps = sel_pps;
    r.age = sel_age;
    case (sel_state)
      cems_pkg::ST_DISC: r.conf = cems_pkg::CONF_DISC;
      cems_pkg::ST_ACQ:  r.conf = cems_pkg::CONF_ACQ;
      cems_pkg::ST_HOLD: r.conf = (sel_age > cems_pkg::LONG_HOLDOVER_MS) ?
                                  cems_pkg::CONF_HOLD_LONG : cems_pkg::CONF_HOLD;
      default:           r.conf = cems_pkg::CONF_FREE;
    endcase
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [cems_pkg::WORD_W-1:0] rand_hz();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    if (r == 2) return $urandom_range(1, 999);
    return 32'd15_998_000 + $urandom_range(0, 4000);
  endfunction

  function automatic logic [cems_pkg::WORD_W-1:0] rand_age();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return $urandom;
    if (r < 4) return cems_pkg::LONG_HOLDOVER_MS - 1 + $urandom_range(0, 2);
    return $urandom_range(0, 1_000_000);
  endfunction

  function automatic logic [cems_pkg::WORD_W-1:0] rand_ticks();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return $urandom;
    if (r < 4) return $urandom_range(0, 100);
    return $urandom_range(0, 100_000_000);
  endfunction

  // time advance scaled to the grace window so that windows both survive and expire
  function automatic logic [cems_pkg::WORD_W-1:0] time_step();
    logic [cems_pkg::WORD_W-1:0] lim;
    lim = (grace_len > 20000) ? 32'd20000 : grace_len;
    if ($urandom_range(99) < 5) return $urandom;
    return $urandom_range(0, lim / 2 + 1);
  endfunction

  function automatic item_t mk_sync(input logic [1:0] st, input logic pps,
                                    input logic [cems_pkg::WORD_W-1:0] now, applied, slow,
                                    good, age);
    item_t it;
    it = '{cems_pkg::CMD_SYNC, st, pps, now, applied, slow, good, age, 32'd0};
    return it;
  endfunction

  function automatic item_t mk_conv(input logic [cems_pkg::WORD_W-1:0] ticks);
    item_t it;
    it = '{cems_pkg::CMD_CONV, cems_pkg::ST_FREE, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
           ticks};
    return it;
  endfunction

  function automatic item_t rand_sync(input logic [1:0] st, input logic pps);
    item_t it;
    wall_ms = wall_ms + time_step();
    it = '{cems_pkg::CMD_SYNC, st, pps, wall_ms, rand_hz(), rand_hz(), rand_hz(), rand_age(),
           $urandom};
    return it;
  endfunction

  function automatic item_t rand_conv();
    item_t it;
    it = '{cems_pkg::CMD_CONV, 2'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
           $urandom, $urandom, rand_ticks()};
    return it;
  endfunction

  task automatic send(input item_t it);
    int unsigned gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? gap_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd <= it.cmd;
    lock_state <= it.state;
    pps_present <= it.pps;
    now_ms <= it.now;
    applied_hz <= it.applied;
    slow_hz <= it.slow;
    last_good_hz <= it.good;
    holdover_ms <= it.age;
    tick_count <= it.ticks;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    export_due.push_back(compute_export(it));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (export_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [cems_pkg::WORD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cems_pkg::REG_NOMINAL) nom_hz = val;
    else grace_len = val;
  endtask

  task automatic test_reset_defaults();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send(mk_conv(32'd0));
    send(mk_conv(32'hFFFF_FFFF));
    send(mk_conv(32'd12_000));
  endtask

  task automatic test_mode_walk();
    send(mk_sync(cems_pkg::ST_ACQ, 1'b0, 32'd100, 32'd0, 32'd7, 32'd9, 32'd0));
    send(mk_sync(cems_pkg::ST_DISC, 1'b1, 32'd200, 32'd1, 32'd16_000_123, 32'd16_000_050,
                 32'd0));
    // mild unlock just before the time wraps
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'hFFFF_FC18, 32'd2, 32'd3, 32'd16_000_321,
                 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd2000, 32'd2, 32'd3, 32'd4, 32'd0));
    send(mk_conv(32'd32_000_642));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd4000, 32'hFFFF_FFFF, 32'd3, 32'd4, 32'd0));
    send(mk_sync(cems_pkg::ST_DISC, 1'b1, 32'd4100, 32'd5, 32'd0, 32'd6, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b0, 32'd4200, 32'd16_000_777, 32'd1, 32'd2, 32'd0));
    send(mk_sync(cems_pkg::ST_DISC, 1'b1, 32'd4300, 32'd1, 32'd16_000_001, 32'd1, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd4400, 32'd1, 32'd1, 32'd0, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b0, 32'd4401, 32'd1, 32'd9, 32'd9, 32'd0));
    // estimate of 1 Hz: quotient wraps
    send(mk_conv(32'hFFFF_FFFF));
    send(mk_sync(cems_pkg::ST_HOLD, 1'b1, 32'd4500, 32'd1, 32'd1, 32'd15_999_000,
                 cems_pkg::LONG_HOLDOVER_MS));
    send(mk_sync(cems_pkg::ST_HOLD, 1'b0, 32'd4600, 32'd1, 32'd1, 32'd0,
                 cems_pkg::LONG_HOLDOVER_MS + 1));
    send(mk_sync(cems_pkg::ST_FREE, 1'b0, 32'd4700, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF));
    send(mk_conv(32'd1));
  endtask

  task automatic test_register_cases();
    drain();
    write_reg(cems_pkg::REG_GRACE, 32'd0);
    write_reg(cems_pkg::REG_NOMINAL, 32'hFFFF_FFFF);
    send(mk_sync(cems_pkg::ST_DISC, 1'b1, 32'd10, 32'd1, 32'd0, 32'd1, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd10, 32'd1, 32'd1, 32'd0, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd10, 32'd3, 32'd1, 32'd1, 32'd0));
    send(mk_sync(cems_pkg::ST_FREE, 1'b0, 32'd11, 32'd1, 32'd1, 32'd1, 32'd0));
    send(mk_conv(32'hFFFF_FFFF));
    drain();
    write_reg(cems_pkg::REG_NOMINAL, 32'd1000);
    send(mk_conv(32'd5));
    send(mk_sync(cems_pkg::ST_FREE, 1'b0, 32'd12, 32'd1, 32'd1, 32'd1, 32'd0));
    drain();
    write_reg(cems_pkg::REG_NOMINAL, 32'd0);
    write_reg(cems_pkg::REG_GRACE, 32'hFFFF_FFFF);
    send(mk_sync(cems_pkg::ST_DISC, 1'b1, 32'd13, 32'd1, 32'd0, 32'd1, 32'd0));
    send(mk_sync(cems_pkg::ST_ACQ, 1'b1, 32'd14, 32'd1, 32'd1, 32'd0, 32'd0));
    send(mk_conv(32'd77));
    drain();
    write_reg(cems_pkg::REG_NOMINAL, cems_pkg::NOMINAL_RESET);
  endtask

  task automatic test_backpressure();
    int k;
    drain();
    tx_idle_pct = 0;
    hold_off = 300;
    while (hold_off != 0) @(negedge clk);
    for (k = 0; k < 12; k++) begin
      if (k % 4 == 3) send(rand_conv());
      else send(rand_sync(2'($urandom), 1'($urandom)));
    end
  endtask

  task automatic run_lock_cycle();
    int unsigned r;
    if ($urandom_range(99) < 30) send(rand_sync(cems_pkg::ST_FREE, 1'($urandom)));
    repeat ($urandom_range(0, 2)) send(rand_sync(cems_pkg::ST_ACQ, 1'($urandom)));
    repeat ($urandom_range(1, 3)) send(rand_sync(cems_pkg::ST_DISC, $urandom_range(99) < 90));
    if ($urandom_range(99) < 30) send(rand_conv());
    send(rand_sync(cems_pkg::ST_ACQ, $urandom_range(99) < 85));
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(99) < 25) send(rand_conv());
      else send(rand_sync(cems_pkg::ST_ACQ, $urandom_range(99) < 85));
    end
    r = $urandom_range(99);
    if (r < 30)
      repeat ($urandom_range(1, 2)) send(rand_sync(cems_pkg::ST_HOLD, 1'($urandom)));
    else if (r < 50) send(rand_sync(cems_pkg::ST_FREE, 1'($urandom)));
  endtask

  task automatic test_random_phase(input logic [cems_pkg::WORD_W-1:0] nom, grace,
                                   input int unsigned tx_pct, rx_pct, count);
    int unsigned goal;
    item_t       it;
    drain();
    write_reg(cems_pkg::REG_NOMINAL, nom);
    write_reg(cems_pkg::REG_GRACE, grace);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = sent + count;
    while (sent < goal) begin
      if ($urandom_range(99) < 80) begin
        run_lock_cycle();
      end else begin
        it = '{1'($urandom), 2'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom};
        send(it);
      end
    end
  endtask

  // receiver: random stall stretches, plus a long hold-off on request
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off != 0) begin
        n = hold_off;
        out_stall <= 1'b1;
        hold_off = 0;
        repeat (n) @(negedge clk);
      end else if ($urandom_range(99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_r = '{ticks_per_second, est_mode, current_state, pps_flag, holdover_age,
                confidence, millis};
      if (export_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%t: output transfer with nothing expected", $realtime);
      end else begin
        exp_r = export_due.pop_front();
        if (got_r !== exp_r) begin
          errors++;
          if (errors <= 10) begin
            $display("%t: mismatch", $realtime);
            $display("  expected tps %0d mode %0d state %0d pps %0d age %0d conf %0d ms %0d",
                     exp_r.tps, exp_r.mode, exp_r.state, exp_r.pps, exp_r.age, exp_r.conf,
                     exp_r.millis);
            $display("  actual   tps %0d mode %0d state %0d pps %0d age %0d conf %0d ms %0d",
                     got_r.tps, got_r.mode, got_r.state, got_r.pps, got_r.age, got_r.conf,
                     got_r.millis);
          end
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = cems_pkg::REG_NOMINAL;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = cems_pkg::CMD_SYNC;
    lock_state = cems_pkg::ST_FREE;
    pps_present = 1'b0;
    now_ms = '0;
    applied_hz = '0;
    slow_hz = '0;
    last_good_hz = '0;
    holdover_ms = '0;
    tick_count = '0;
    nom_hz = cems_pkg::NOMINAL_RESET;
    grace_len = cems_pkg::GRACE_RESET;
    sel_state = cems_pkg::ST_FREE;
    sel_mode = cems_pkg::MD_NOMINAL;
    sel_freq = cems_pkg::NOMINAL_RESET;
    sel_anchor = cems_pkg::NOMINAL_RESET;
    sel_grace_t0 = '0;
    sel_pps = 1'b0;
    sel_locked = 1'b0;
    sel_age = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_mode_walk();
    test_register_cases();
    test_backpressure();
    test_random_phase(cems_pkg::NOMINAL_RESET, cems_pkg::GRACE_RESET, 0, 0, 300);
    test_random_phase(32'd1000, 32'd0, 30, 30, 300);
    test_random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 50, 20, 300);
    test_random_phase($urandom_range(32'hFFFF_FFFF, 1000), $urandom_range(1, 3000), 20, 50,
                      300);
    test_random_phase(32'd15_990_000 + $urandom_range(0, 20_000), 32'd1, 40, 40, 300);
    test_random_phase(cems_pkg::NOMINAL_RESET, 32'd2000, 10, 10, 300);

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && export_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
